FILE: hw/rtl/sdet_pkg.sv
// Shared types and constants for the determinant sign unit.
package sdet_pkg;

  // Sign codes on det_sign
  localparam logic [1:0] SIGN_NEG  = 2'b11;
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;

  // Front stage outcome: concluded at once, or needs the reduction
  typedef enum logic [1:0] {
    CLS_DONE   = 2'b01,
    CLS_REDUCE = 2'b10
  } cls_t;

  // Back stage states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_DIVY  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_POST  = 7'b0010000,
    ST_CHECK = 7'b0100000,
    ST_OUT   = 7'b1000000
  } bst_t;

endpackage

FILE: hw/rtl/sign_of_det2x2_iterative_unit.sv
// Top level of the exact 2x2 determinant sign unit.
// Usage: drive ax, ay, bx, by and raise start while busy is low; the word is
// taken at that clock edge. The unit returns det_sign (-1, 0, +1 as 2-bit
// two's complement) of ax*by - ay*bx, marked by a one-cycle done strobe.
// The receiver cannot stall; the result must be taken in that cycle.
// When zero entries or the sign pattern settle the answer, the word passes the
// front stage register and the back stage result register. Otherwise each half
// round runs two bit-serial divisions (x quotient, y quotient), a product
// step and two test steps. Item time is therefore set by the serial divider
// and the number of half rounds.
// One word is in flight at a time; busy stays high from acceptance until the
// done strobe. Reset clears busy and all control state.
module sign_of_det2x2_iterative_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] ax,
  input  logic [COORD_WIDTH-1:0] ay,
  input  logic [COORD_WIDTH-1:0] bx,
  input  logic [COORD_WIDTH-1:0] by,
  output logic                   done,
  output logic [1:0]             det_sign
);

  logic                   q_push;
  sdet_pkg::cls_t         q_cls;
  logic                   q_neg;
  logic [COORD_WIDTH-1:0] q_x1, q_y1, q_x2, q_y2;
  logic                   bidle;
  logic                   pend;

  // Hold busy from acceptance to the done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (start && !busy) begin
      pend <= 1'b1;
    end else if (done) begin
      pend <= 1'b0;
    end
  end
  assign busy = pend;

  sdet_front #(.W(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .ax(ax), .ay(ay), .bx(bx), .by(by),
    .q_push(q_push), .q_cls(q_cls), .q_neg(q_neg),
    .q_x1(q_x1), .q_y1(q_y1), .q_x2(q_x2), .q_y2(q_y2)
  );

  sdet_back #(.W(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_push(q_push), .q_cls(q_cls), .q_neg(q_neg),
    .q_x1(q_x1), .q_y1(q_y1), .q_x2(q_x2), .q_y2(q_y2),
    .idle(bidle), .done(done), .det_sign(det_sign)
  );

  a_idle_busy: assert property (@(posedge clk) disable iff (rst)
    !busy |-> bidle)
    else $error("back stage active while not busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result without pending word");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result");

endmodule

FILE: hw/rtl/sdet_front.sv
// Front stage: zero handling, reflection and ordering of the two vectors.
module sdet_front #(
  parameter int W = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [W-1:0]  ax,
  input  logic [W-1:0]  ay,
  input  logic [W-1:0]  bx,
  input  logic [W-1:0]  by,
  output logic          q_push,
  output sdet_pkg::cls_t q_cls,
  output logic          q_neg,
  output logic [W-1:0]  q_x1,
  output logic [W-1:0]  q_y1,
  output logic [W-1:0]  q_x2,
  output logic [W-1:0]  q_y2
);

  logic         nx1, ny1, nx2, ny2;
  logic [W-1:0] mx1, my1, mx2, my2;
  logic         sx1, sy1, sx2, sy2;
  logic [W-1:0] tx1, ty1, tx2, ty2;
  logic         s_neg;
  logic         done_c;
  logic         res_neg;
  logic         res_zero;

  assign nx1 = ax[W-1];
  assign ny1 = ay[W-1];
  assign nx2 = bx[W-1];
  assign ny2 = by[W-1];
  assign mx1 = nx1 ? (~ax + 1'b1) : ax;
  assign my1 = ny1 ? (~ay + 1'b1) : ay;
  assign mx2 = nx2 ? (~bx + 1'b1) : bx;
  assign my2 = ny2 ? (~by + 1'b1) : by;

  // Classify and normalise the item
  always_comb begin
    s_neg = 1'b0;
    done_c = 1'b0;
    res_neg = 1'b0;
    res_zero = 1'b0;
    tx1 = mx1; ty1 = my1; tx2 = mx2; ty2 = my2;
    sx1 = nx1; sy1 = ny1; sx2 = nx2; sy2 = ny2;
    if (mx1 == '0 || my2 == '0) begin
      done_c = 1'b1;
      if (my1 == '0 || mx2 == '0) begin
        res_zero = 1'b1;
      end else begin
        res_neg = ~(ny1 ^ nx2);
      end
    end else if (my1 == '0 || mx2 == '0) begin
      done_c = 1'b1;
      res_neg = nx1 ^ ny2;
    end else begin
      if (!ny1) begin
        if (!ny2) begin
          if (my1 > my2) begin
            s_neg = 1'b1;
            tx1 = mx2; sx1 = nx2; ty1 = my2; sy1 = ny2;
            tx2 = mx1; sx2 = nx1; ty2 = my1; sy2 = ny1;
          end
        end else if (my1 <= my2) begin
          s_neg = 1'b1;
          sx2 = ~nx2; sy2 = ~ny2;
        end else begin
          tx1 = mx2; sx1 = ~nx2; ty1 = my2; sy1 = ~ny2;
          tx2 = mx1; sx2 = nx1; ty2 = my1; sy2 = ny1;
        end
      end else begin
        if (!ny2) begin
          if (my1 <= my2) begin
            s_neg = 1'b1;
            sx1 = ~nx1; sy1 = ~ny1;
          end else begin
            tx1 = mx2; sx1 = nx2; ty1 = my2; sy1 = ny2;
            tx2 = mx1; sx2 = ~nx1; ty2 = my1; sy2 = ~ny1;
          end
        end else if (my1 <= my2) begin
          sx1 = ~nx1; sy1 = ~ny1; sx2 = ~nx2; sy2 = ~ny2;
        end else begin
          s_neg = 1'b1;
          tx1 = mx2; sx1 = ~nx2; ty1 = my2; sy1 = ~ny2;
          tx2 = mx1; sx2 = ~nx1; ty2 = my1; sy2 = ~ny1;
        end
      end
      // x entries positive, or conclude
      if (!sx1) begin
        if (sx2 || tx1 > tx2) begin
          done_c = 1'b1;
          res_neg = s_neg;
        end
      end else begin
        if (!sx2 || tx1 > tx2) begin
          done_c = 1'b1;
          res_neg = ~s_neg;
        end else begin
          s_neg = ~s_neg;
        end
      end
    end
  end

  // Register the classified word into the queue slot
  always_ff @(posedge clk) begin
    if (rst) begin
      q_push <= 1'b0;
    end else begin
      q_push <= in_valid;
    end
    q_cls  <= done_c ? sdet_pkg::CLS_DONE : sdet_pkg::CLS_REDUCE;
    q_neg  <= done_c ? res_neg : s_neg;
    q_x1   <= res_zero ? '0 : tx1;
    q_y1   <= res_zero ? '0 : ty1;
    q_x2   <= tx2;
    q_y2   <= ty2;
  end

endmodule

FILE: hw/rtl/sdet_back.sv
// Back stage: alternating Euclid-like reduction with a shared serial divider.
module sdet_back #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_push,
  input  sdet_pkg::cls_t q_cls,
  input  logic           q_neg,
  input  logic [W-1:0]   q_x1,
  input  logic [W-1:0]   q_y1,
  input  logic [W-1:0]   q_x2,
  input  logic [W-1:0]   q_y2,
  output logic           idle,
  output logic           done,
  output logic [1:0]     det_sign
);

  localparam int CW = $clog2(W + 1);

  sdet_pkg::bst_t st;
  logic [W-1:0] a, b, c, d; // a,b: divisor pair (X,Y) ; c,d: dividend pair
  logic         s;
  logic [W-1:0] rem, quo, dvs;
  logic [W:0]   trial;
  logic [CW-1:0] cnt;
  logic [W-1:0] kx;       // x quotient
  logic [W-1:0] xr;       // x remainder
  logic [2*W-1:0] prod;
  logic [W-1:0] dn;

  assign trial = {rem, quo[W-1]} - {1'b0, dvs};
  assign idle  = (st == sdet_pkg::ST_IDLE);
  assign dn    = d - prod[W-1:0];

  // Run the reduction one step a state
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= sdet_pkg::ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        sdet_pkg::ST_IDLE: begin
          if (q_push) begin
            if (q_cls == sdet_pkg::CLS_DONE) begin
              done     <= 1'b1;
              det_sign <= (q_x1 == '0 && q_y1 == '0) ? sdet_pkg::SIGN_ZERO :
                          q_neg ? sdet_pkg::SIGN_NEG : sdet_pkg::SIGN_POS;
              // zero flagged by cleared x1 and y1 only when zero case
            end else begin
              a <= q_x1; b <= q_y1; c <= q_x2; d <= q_y2; s <= q_neg;
              rem <= '0; quo <= q_x2; dvs <= q_x1; cnt <= '0;
              st <= sdet_pkg::ST_DIV;
            end
          end
        end
        sdet_pkg::ST_DIV, sdet_pkg::ST_DIVY: begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= {rem[W-2:0], quo[W-1]};
            quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            cnt <= '0;
            if (st == sdet_pkg::ST_DIV) begin
              kx  <= {quo[W-2:0], ~trial[W]};
              xr  <= trial[W] ? {rem[W-2:0], quo[W-1]} : trial[W-1:0];
              rem <= '0; quo <= d; dvs <= b;
              st  <= sdet_pkg::ST_DIVY;
            end else if (kx > {quo[W-2:0], ~trial[W]}) begin
              done <= 1'b1;
              det_sign <= s ? sdet_pkg::SIGN_POS : sdet_pkg::SIGN_NEG;
              st <= sdet_pkg::ST_IDLE;
            end else begin
              st <= sdet_pkg::ST_MUL;
            end
          end
        end
        sdet_pkg::ST_MUL: begin
          prod <= kx * b;
          st   <= sdet_pkg::ST_POST;
        end
        sdet_pkg::ST_POST: begin
          if (dn > b) begin
            done <= 1'b1;
            det_sign <= s ? sdet_pkg::SIGN_NEG : sdet_pkg::SIGN_POS;
            st <= sdet_pkg::ST_IDLE;
          end else if (a - xr > xr) begin
            if (b - dn < dn) begin
              done <= 1'b1;
              det_sign <= s ? sdet_pkg::SIGN_NEG : sdet_pkg::SIGN_POS;
              st <= sdet_pkg::ST_IDLE;
            end else begin
              c <= xr; d <= dn; st <= sdet_pkg::ST_CHECK;
            end
          end else begin
            if (b - dn > dn) begin
              done <= 1'b1;
              det_sign <= s ? sdet_pkg::SIGN_POS : sdet_pkg::SIGN_NEG;
              st <= sdet_pkg::ST_IDLE;
            end else begin
              c <= a - xr; d <= b - dn; s <= ~s; st <= sdet_pkg::ST_CHECK;
            end
          end
        end
        sdet_pkg::ST_CHECK: begin
          // Zero tests, then swap roles for the next half round
          if (d == '0) begin
            done <= 1'b1;
            det_sign <= (c == '0) ? sdet_pkg::SIGN_ZERO :
                        s ? sdet_pkg::SIGN_POS : sdet_pkg::SIGN_NEG;
            st <= sdet_pkg::ST_IDLE;
          end else if (c == '0) begin
            done <= 1'b1;
            det_sign <= s ? sdet_pkg::SIGN_NEG : sdet_pkg::SIGN_POS;
            st <= sdet_pkg::ST_IDLE;
          end else begin
            a <= c; b <= d; c <= a; d <= b; s <= ~s;
            rem <= '0; quo <= a; dvs <= c;
            st <= sdet_pkg::ST_DIV;
          end
        end
        default: st <= sdet_pkg::ST_IDLE;
      endcase
    end
  end

  // Back state is one-hot; results and queue pushes only meet the idle state
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(st))
    else $error("back state not one-hot");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> st == sdet_pkg::ST_IDLE)
    else $error("result while still reducing");
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    q_push |-> st == sdet_pkg::ST_IDLE)
    else $error("queue pushed into busy back stage");

endmodule
